// ===== rtl/core/tte_pkg.sv =====
// Package for the two-tap echo filter: widths, reset values, register map,
// and the control struct passed from the address stage to the MAC pipeline.
// No dependencies.
package tte_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int GAIN_W         = 16;
  localparam int DELAY_W        = 11;
  localparam int PROD_W         = 2 * SAMPLE_W;
  localparam int ACC_W          = PROD_W + 1;
  localparam int FRAC_BITS      = 15;
  localparam int HIST_DEPTH_DEF = 2048;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0]  GAIN_DIRECT_RST  = 16'd16384;
  localparam logic [GAIN_W-1:0]  GAIN_FIRST_RST   = 16'd9830;
  localparam logic [GAIN_W-1:0]  GAIN_SECOND_RST  = 16'd6554;
  localparam logic [DELAY_W-1:0] DELAY_FIRST_RST  = 11'd800;
  localparam logic [DELAY_W-1:0] DELAY_SECOND_RST = 11'd1200;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_GAIN_DIRECT  = 3'd0,
    REG_GAIN_FIRST   = 3'd1,
    REG_GAIN_SECOND  = 3'd2,
    REG_DELAY_FIRST  = 3'd3,
    REG_DELAY_SECOND = 3'd4
  } reg_idx_t;

  // Per-beat tap control, registered alongside the history read data
  typedef struct packed {
    logic                 vld;
    logic [SAMPLE_W-1:0]  x;
    logic                 cur1;   // first tap has zero delay: use x
    logic                 use1;   // first tap reads history
    logic                 cur2;
    logic                 use2;
  } tap_ctl_t;

endpackage

// ===== rtl/core/tte_hist_mem.sv =====
// History ring storage: one write port, two registered read ports.
// Read-before-write on a same-address access. Depends on tte_pkg.
module tte_hist_mem
  import tte_pkg::*;
#(
  parameter int DEPTH = HIST_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr1,
  input  logic [AW-1:0]       raddr2,
  output logic [SAMPLE_W-1:0] rdata1,
  output logic [SAMPLE_W-1:0] rdata2
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata1_r;
  logic [SAMPLE_W-1:0] rdata2_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two read ports, held while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata1_r <= mem[raddr1];
      rdata2_r <= mem[raddr2];
    end
  end

  assign rdata1 = rdata1_r;
  assign rdata2 = rdata2_r;

endmodule

// ===== rtl/core/tte_mac.sv =====
// Multiply-accumulate pipeline: tap select and three products, sum,
// truncate toward zero and saturate into the output register. Depends on tte_pkg.
module tte_mac
  import tte_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  tap_ctl_t                   ctl,
  input  logic [SAMPLE_W-1:0]        rd1,
  input  logic [SAMPLE_W-1:0]        rd2,
  input  logic signed [GAIN_W-1:0]   gain_direct,
  input  logic signed [GAIN_W-1:0]   gain_first,
  input  logic signed [GAIN_W-1:0]   gain_second,
  output logic                       out_valid,
  output logic [SAMPLE_W-1:0]        out_sample
);

  localparam int Q_W = ACC_W - FRAC_BITS;

  logic signed [SAMPLE_W-1:0] tap0, tap1, tap2;
  logic signed [PROD_W-1:0]   p0_r, p1_r, p2_r;
  logic                       s2_vld_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       s3_vld_r;
  logic signed [ACC_W:0]      acc_adj;
  logic signed [Q_W:0]        quo;
  logic [SAMPLE_W-1:0]        sat_val;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_sample_r;

  // tap select: current sample, history, or nothing yet
  always_comb begin
    tap0 = $signed(ctl.x);
    tap1 = ctl.cur1 ? $signed(ctl.x) : (ctl.use1 ? $signed(rd1) : '0);
    tap2 = ctl.cur2 ? $signed(ctl.x) : (ctl.use2 ? $signed(rd2) : '0);
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= gain_direct * tap0;
      p1_r <= gain_first  * tap1;
      p2_r <= gain_second * tap2;
    end
  end

  // stage 3: sum of products
  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r);
    end
  end

  // shift right with truncation toward zero: bias negatives before the shift
  always_comb begin
    acc_adj = (ACC_W + 1)'(acc_r);
    if (acc_r < 0) begin
      acc_adj = acc_adj + (ACC_W + 1)'((1 << FRAC_BITS) - 1);
    end
    quo = (Q_W + 1)'(acc_adj >>> FRAC_BITS);
    if (quo > (Q_W + 1)'(32767)) begin
      sat_val = 16'h7FFF;
    end else if (quo < -(Q_W + 1)'(32768)) begin
      sat_val = 16'h8000;
    end else begin
      sat_val = quo[SAMPLE_W-1:0];
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_sample_r <= sat_val;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s2_vld_r    <= ctl.vld;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= s3_vld_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

// ===== rtl/core/two_tap_echo_filter.sv =====
// An accepted input beat passes the stage 1, product, sum and output registers to out_valid.
// Throughput: one beat per cycle unless the output stalls; the history memory reads both taps and
// writes the new sample in the accept cycle, and each tap has its own multiplier.
// Stalls on the output freeze the whole pipeline and raise in_stall.
// Reset (rst_n, synchronous) clears the pipeline, write position and fill count,
// and loads the gain and delay registers; history contents are not cleared.
module two_tap_echo_filter
  import tte_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SAMPLE_W-1:0]   out_sample_out,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;

  logic [GAIN_W-1:0]  gain_direct_r, gain_first_r, gain_second_r;
  logic [DELAY_W-1:0] delay_first_r, delay_second_r;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic               en;
  logic               accept;
  logic               cfg_wr;
  reg_idx_t           reg_idx;
  logic [CW-1:0]      diff1, diff2, idx1, idx2;
  logic [AW-1:0]      raddr1, raddr2;
  logic               use1, use2;
  logic [SAMPLE_W-1:0] rd1, rd2;
  logic               s1_vld_r;
  tap_ctl_t           s1_r;
  tap_ctl_t           s1_ctl;

  // pipeline advances unless the output register is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_direct_r  <= GAIN_DIRECT_RST;
      gain_first_r   <= GAIN_FIRST_RST;
      gain_second_r  <= GAIN_SECOND_RST;
      delay_first_r  <= DELAY_FIRST_RST;
      delay_second_r <= DELAY_SECOND_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN_DIRECT:  gain_direct_r  <= pwdata[GAIN_W-1:0];
        REG_GAIN_FIRST:   gain_first_r   <= pwdata[GAIN_W-1:0];
        REG_GAIN_SECOND:  gain_second_r  <= pwdata[GAIN_W-1:0];
        REG_DELAY_FIRST:  delay_first_r  <= pwdata[DELAY_W-1:0];
        REG_DELAY_SECOND: delay_second_r <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_GAIN_DIRECT:  prdata = CFG_DATA_W'(gain_direct_r);
      REG_GAIN_FIRST:   prdata = CFG_DATA_W'(gain_first_r);
      REG_GAIN_SECOND:  prdata = CFG_DATA_W'(gain_second_r);
      REG_DELAY_FIRST:  prdata = CFG_DATA_W'(delay_first_r);
      REG_DELAY_SECOND: prdata = CFG_DATA_W'(delay_second_r);
      default:          prdata = '0;
    endcase
  end

  // tap addresses: (wp - d) wrapped into the ring
  always_comb begin
    diff1  = CW'(wp_r) - CW'(delay_first_r);
    diff2  = CW'(wp_r) - CW'(delay_second_r);
    idx1   = diff1[CW-1] ? diff1 + CW'(HISTORY_DEPTH) : diff1;
    idx2   = diff2[CW-1] ? diff2 + CW'(HISTORY_DEPTH) : diff2;
    raddr1 = idx1[AW-1:0];
    raddr2 = idx2[AW-1:0];
    // fill never exceeds the depth, so this also rules out delays past the ring
    use1   = (delay_first_r != '0)  && (CW'(delay_first_r)  <= CW'(fill_r));
    use2   = (delay_second_r != '0) && (CW'(delay_second_r) <= CW'(fill_r));
  end

  // write position and saturating fill count
  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (accept) begin
      wp_nxt = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (fill_r != FW'(HISTORY_DEPTH)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  // stage 1: tap control registered next to the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.vld  <= 1'b0;
      s1_r.x    <= in_sample_in;
      s1_r.cur1 <= (delay_first_r == '0);
      s1_r.use1 <= use1;
      s1_r.cur2 <= (delay_second_r == '0);
      s1_r.use2 <= use2;
    end
  end

  always_comb begin
    s1_ctl     = s1_r;
    s1_ctl.vld = s1_vld_r;
  end

  tte_hist_mem #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_mem (
    .clk    (clk),
    .we     (accept),
    .waddr  (wp_r),
    .wdata  (in_sample_in),
    .re     (en),
    .raddr1 (raddr1),
    .raddr2 (raddr2),
    .rdata1 (rd1),
    .rdata2 (rd2)
  );

  tte_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .ctl         (s1_ctl),
    .rd1         (rd1),
    .rd2         (rd2),
    .gain_direct (gain_direct_r),
    .gain_first  (gain_first_r),
    .gain_second (gain_second_r),
    .out_valid   (out_valid),
    .out_sample  (out_sample_out)
  );

`ifndef SYNTHESIS
  // fill count saturates at the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  // write position stays inside the ring
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= AW'(HISTORY_DEPTH - 1))
    else $error("write position outside ring");

  // each accepted beat advances the write position by one, with wrap
  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (wp_r == (($past(wp_r) == AW'(HISTORY_DEPTH - 1)) ? '0 : $past(wp_r) + 1'b1)))
    else $error("write position did not advance");

  // write position and fill count only move on an accepted beat
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(wp_r) && $stable(fill_r)))
    else $error("ring state changed without a beat");

  // input is held off only by a held output beat
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");
`endif

endmodule

// ===== tb/two_tap_echo_filter_checker.sv =====
// Checker for the two-tap echo filter: snoops the config bus and both channels,
// predicts every output sample and compares it with what the block delivers.
// Depends on tte_pkg for widths, reset values and the register map.
module two_tap_echo_filter_checker
  import tte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample_in,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SAMPLE_W-1:0]   out_sample_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    pending,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DEPTH  = HIST_DEPTH_DEF;
  localparam longint SAT_HI = 32767;
  localparam longint SAT_LO = -32768;

  // shadow of the filter: sample history, fill tracking, register copies
  logic signed [SAMPLE_W-1:0] history [DEPTH];
  int unsigned                wr_pos;
  int unsigned                filled;
  logic signed [GAIN_W-1:0]   g_direct, g_first, g_second;
  logic [DELAY_W-1:0]         d_first, d_second;

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  logic signed [SAMPLE_W-1:0] want;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  // sample seen by a tap; zero delay means the current sample, unfilled adds zero
  function automatic longint tap_value(logic [DELAY_W-1:0] d,
                                       logic signed [SAMPLE_W-1:0] x);
    int unsigned idx;
    if (d == 0) return longint'(x);
    if (d > filled || d > DEPTH) return 0;
    idx = (wr_pos + DEPTH - d) % DEPTH;
    return longint'(history[idx]);
  endfunction

  // three-tap MAC, shift by 15 toward zero, clamp to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] echo_sample(
    logic signed [SAMPLE_W-1:0] x);
    longint acc;
    longint q;
    acc = longint'(g_direct) * longint'(x)
        + longint'(g_first)  * tap_value(d_first, x)
        + longint'(g_second) * tap_value(d_second, x);
    q = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
    if (q > SAT_HI) q = SAT_HI;
    else if (q < SAT_LO) q = SAT_LO;
    return q[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_pos   = 0;
      filled   = 0;
      g_direct = GAIN_DIRECT_RST;
      g_first  = GAIN_FIRST_RST;
      g_second = GAIN_SECOND_RST;
      d_first  = DELAY_FIRST_RST;
      d_second = DELAY_SECOND_RST;
      expected_samples.delete();
    end else begin
      // input beat: predict, then push the sample into the history
      if (in_valid && !in_stall) begin
        expected_samples.push_back(echo_sample(in_sample_in));
        history[wr_pos] = in_sample_in;
        wr_pos = (wr_pos + 1) % DEPTH;
        if (filled < DEPTH) filled++;
      end
      // output beat: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected sample_out %0d, expected none",
                   $time, $signed(out_sample_out));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want) begin
            fail_count++;
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want, $signed(out_sample_out));
          end
        end
      end
      // register write on the access phase
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
          REG_GAIN_DIRECT:  g_direct = pwdata[GAIN_W-1:0];
          REG_GAIN_FIRST:   g_first  = pwdata[GAIN_W-1:0];
          REG_GAIN_SECOND:  g_second = pwdata[GAIN_W-1:0];
          REG_DELAY_FIRST:  d_first  = pwdata[DELAY_W-1:0];
          REG_DELAY_SECOND: d_second = pwdata[DELAY_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_samples.size();
  end

endmodule

// ===== tb/two_tap_echo_filter_tb.sv =====
// Testbench top for the two-tap echo filter: clock, reset, config writes,
// sample stimulus with random idling and back-pressure, watchdog and verdict.
// Depends on tte_pkg, two_tap_echo_filter and two_tap_echo_filter_checker.
module two_tap_echo_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tte_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 48;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_sample_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [SAMPLE_W-1:0]   out_sample_out;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  int                    pending;
  int                    fail_count;

  // idling controls (rx_idle_en and hold_req shared with the receiver process) and run counters
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;
  int n_samples;
  int n_settings;

  two_tap_echo_filter dut (.*);
  two_tap_echo_filter_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int rx_wait;
    rx_wait   = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_wait  = HOLD_CYCLES;
      end else if (rx_wait == 0 && rx_idle_en && $urandom_range(0, 4) == 0) begin
        rx_wait = $urandom_range(1, 4);
      end
      if (rx_wait > 0) begin
        out_stall = 1'b1;
        rx_wait--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // watchdog: ends the run when no beat moves for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable))
        stuck = 0;
      else
        stuck++;
    end
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SAMPLE_W'($urandom_range(0, 3) - 2);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // one input beat, optionally preceded by an idle burst
  task automatic push_sample(logic [SAMPLE_W-1:0] s);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid     = 1'b0;
      in_sample_in = SAMPLE_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_sample_in = s;
    do @(posedge clk); while (in_stall);
    n_samples++;
  endtask

  // stop sending and wait until every predicted sample has come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic cfg_write(reg_idx_t r, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_filter(logic [GAIN_W-1:0] gd, logic [GAIN_W-1:0] g1,
                            logic [GAIN_W-1:0] g2, logic [DELAY_W-1:0] d1,
                            logic [DELAY_W-1:0] d2);
    cfg_write(REG_GAIN_DIRECT, CFG_DATA_W'(gd));
    cfg_write(REG_GAIN_FIRST, CFG_DATA_W'(g1));
    cfg_write(REG_GAIN_SECOND, CFG_DATA_W'(g2));
    cfg_write(REG_DELAY_FIRST, CFG_DATA_W'(d1));
    cfg_write(REG_DELAY_SECOND, CFG_DATA_W'(d2));
    n_settings++;
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    tx_idle_en   = 1'b0;
    rx_idle_en   = 1'b0;
    hold_req     = 1'b0;
    n_samples    = 0;
    n_settings   = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: taps not filled yet, half gain truncates toward zero
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0000);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    drain();

    // most negative gains, zero delay on one tap: both saturation bounds
    set_filter(16'h8000, 16'h8000, 16'h8000, 11'd0, 11'd1);
    push_sample(16'h8000);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h7FFF);
    drain();

    // most positive gains, longest delay stays unfilled
    set_filter(16'h7FFF, 16'h7FFF, 16'h7FFF, 11'd2047, 11'd2);
    push_sample(16'h7FFF);
    push_sample(16'h7FFF);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h8000);
    push_sample(16'h8000);
    push_sample(16'hFFFF);
    push_sample(16'h0001);
    drain();

    // random settings, short delays mostly; one phase has a long output hold-off
    for (int p = 0; p < 7; p++) begin
      tx_idle_en = (p != 3);
      rx_idle_en = (p != 4);
      set_filter(pick_gain(), pick_gain(), pick_gain(),
                 DELAY_W'($urandom_range(0, (p == 5) ? 400 : 24)),
                 DELAY_W'($urandom_range(0, (p == 6) ? 2047 : 24)));
      for (int i = 0; i < 55; i++) begin
        if (p == 1 && i == 10) hold_req = 1'b1;
        push_sample(pick_sample());
      end
      drain();
    end

    // short delays, no idling
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_filter(pick_gain(), pick_gain(), pick_gain(),
               DELAY_W'($urandom_range(1, 8)), DELAY_W'($urandom_range(0, 40)));
    repeat (40) push_sample(pick_sample());
    drain();
    repeat (10) @(posedge clk);

    $display("run covered %0d samples over %0d filter settings,", n_samples,
             n_settings);
    $display("including gain and delay extremes, zero delay, unfilled taps and a long hold-off");
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tte_pkg.sv
rtl/core/tte_hist_mem.sv
rtl/core/tte_mac.sv
rtl/core/two_tap_echo_filter.sv
tb/two_tap_echo_filter_checker.sv
tb/two_tap_echo_filter_tb.sv
